// File: rtl/kped_pkg.sv
// Shared types, constants and register map for the key press event detector.
`timescale 1ns / 1ps

package kped_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int IN_W         = 4;
    localparam int MAX_RESULTS  = 4;
    localparam int CNT_W        = 16;
    localparam int CODE_W       = 8;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int KEY_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CODE    = 3'd4;

    localparam logic [CNT_W-1:0]  FILTER_TICKS_RST = 16'd10;
    localparam logic [CNT_W-1:0]  LONG_TICKS_RST   = 16'd200;
    localparam logic [CNT_W-1:0]  REPEAT_TICKS_RST = 16'd0;
    localparam logic [CODE_W-1:0] SHORT_CODE_RST   = 8'd1;
    localparam logic [CODE_W-1:0] LONG_CODE_RST    = 8'd3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_DOWN     = 3'd2,
        PH_LONG     = 3'd3,
        PH_REPEAT   = 3'd4,
        PH_RELEASE  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0]  filter_ticks;
        logic [CNT_W-1:0]  long_ticks;
        logic [CNT_W-1:0]  repeat_ticks;
        logic [CODE_W-1:0] short_code;
        logic [CODE_W-1:0] long_code;
    } cfg_t;

    typedef struct packed {
        logic              fire;
        logic [CODE_W-1:0] code;
    } lane_evt_t;

endpackage

// File: rtl/key_press_event_detector_core.sv
// Top level: config registers, one lane per key, and the event merge.
// A tick's events are registered in the pending mask, then each in the output registers.
// Throughput: one event per cycle unless out_stall; a tick's events (at most four kept) hold
// the input until the last is taken; one tick per cycle while the merge stage is empty.
// Reset: asynchronous, active low; all keys idle with counters at zero, registers at defaults.
`timescale 1ns / 1ps

module key_press_event_detector_core
    import kped_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_W-1:0]      pressed_mask,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_IDX_W-1:0] key_index,
    output logic [CODE_W-1:0]    event_code,
    output logic                 last_event
);

    cfg_t                     cfg_reg;
    logic                     busy;
    logic                     step;
    logic [NUM_KEYS-1:0]      held;
    lane_evt_t [NUM_KEYS-1:0] evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_ticks <= FILTER_TICKS_RST;
            cfg_reg.long_ticks   <= LONG_TICKS_RST;
            cfg_reg.repeat_ticks <= REPEAT_TICKS_RST;
            cfg_reg.short_code   <= SHORT_CODE_RST;
            cfg_reg.long_code    <= LONG_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_TICKS: cfg_reg.filter_ticks <= cfg_data[CNT_W-1:0];
                REG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_data[CNT_W-1:0];
                REG_REPEAT_TICKS: cfg_reg.repeat_ticks <= cfg_data[CNT_W-1:0];
                REG_SHORT_CODE:   cfg_reg.short_code   <= cfg_data[CODE_W-1:0];
                REG_LONG_CODE:    cfg_reg.long_code    <= cfg_data[CODE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = busy;
    assign step     = in_valid && !busy;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_lane
            // Keys past the input width never read as held.
            if (k < IN_W)
            begin : g_in
                assign held[k] = pressed_mask[k];
            end
            else
            begin : g_none
                assign held[k] = 1'b0;
            end

            kped_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .cfg   (cfg_reg),
                .held  (held[k]),
                .step  (step),
                .evt   (evt[k])
            );
        end
    endgenerate

    kped_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .evt        (evt),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_index  (key_index),
        .event_code (event_code),
        .last_event (last_event)
    );

endmodule

// File: rtl/kped_lane.sv
// Per-key lane: phase state machine and tick counter for one key.
`timescale 1ns / 1ps

module kped_lane
    import kped_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      held,
    input  logic      step,
    output lane_evt_t evt
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_inc;

    assign count_inc = count_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        evt.fire   = 1'b0;
        evt.code   = cfg.short_code;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (held)
                begin
                    phase_next = PH_DEBOUNCE;
                    count_next = '0;
                end
            end
            PH_DEBOUNCE:
            begin
                if (held)
                begin
                    phase_next = PH_DOWN;
                    count_next = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DOWN:
            begin
                if (held)
                begin
                    count_next = count_inc;
                    if (count_inc >= cfg.filter_ticks)
                    begin
                        phase_next = (cfg.long_ticks != '0) ? PH_LONG : PH_RELEASE;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LONG:
            begin
                if (held)
                begin
                    count_next = count_inc;
                    if (count_inc >= cfg.long_ticks)
                    begin
                        evt.fire = 1'b1;
                        evt.code = cfg.long_code;
                        if (cfg.repeat_ticks != '0)
                        begin
                            phase_next = PH_REPEAT;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_RELEASE;
                        end
                    end
                end
                else
                begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_REPEAT:
            begin
                if (held)
                begin
                    count_next = count_inc;
                    if (count_inc >= cfg.repeat_ticks)
                    begin
                        evt.fire   = 1'b1;
                        count_next = '0;
                    end
                end
                else
                begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                evt.fire   = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/kped_merge.sv
// Event merge: captures lane events of a tick and sends them out in key order.
`timescale 1ns / 1ps

module kped_merge
    import kped_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  lane_evt_t [NUM_KEYS-1:0]     evt,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [KEY_IDX_W-1:0]         key_index,
    output logic [CODE_W-1:0]            event_code,
    output logic                         last_event
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int NUM_W = $clog2(MAX_RESULTS + 1);
    localparam logic [NUM_W-1:0] MAX_R = NUM_W'(MAX_RESULTS);

    logic [NUM_KEYS-1:0]  pend_mask_reg;
    logic [CODE_W-1:0]    pend_code_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]  rest_mask;
    logic [NUM_KEYS-1:0]  keep_mask;
    logic [NUM_W-1:0]     keep_cnt;
    logic [KEY_W-1:0]     sel;
    logic [KEY_W+1:0]     sel_ext;
    logic                 have;
    logic                 out_load;

    logic                 out_valid_reg;
    logic [KEY_IDX_W-1:0] key_index_reg;
    logic [CODE_W-1:0]    event_code_reg;
    logic                 last_event_reg;

    // Lowest pending key goes first; clearing it leaves the rest.
    always_comb
    begin
        sel = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (pend_mask_reg[k])
            begin
                sel = KEY_W'(k);
            end
        end
    end

    assign sel_ext   = {2'b00, sel};
    assign rest_mask = pend_mask_reg & (pend_mask_reg - NUM_KEYS'(1));
    assign have      = |pend_mask_reg;
    assign out_load  = have && (!out_valid_reg || !out_stall);
    assign busy      = have && !((rest_mask == '0) && out_load);

    // Keep only the first events of a tick that fit in one burst.
    always_comb
    begin
        keep_mask = '0;
        keep_cnt  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (evt[k].fire && (keep_cnt < MAX_R))
            begin
                keep_mask[k] = 1'b1;
                keep_cnt     = keep_cnt + NUM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pend_mask_reg <= keep_mask;
            end
            else if (out_load)
            begin
                pend_mask_reg <= rest_mask;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                pend_code_reg[k] <= evt[k].code;
            end
        end
        if (out_load)
        begin
            key_index_reg  <= sel_ext[KEY_IDX_W-1:0];
            event_code_reg <= pend_code_reg[sel];
            last_event_reg <= (rest_mask == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_index  = key_index_reg;
    assign event_code = event_code_reg;
    assign last_event = last_event_reg;

    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ($countones(pend_mask_reg) <= 1))
        else $error("tick loaded over pending events");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pend_mask_reg) <= MAX_RESULTS)
        else $error("more pending events than one burst allows");

    a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_event_reg) |-> (pend_mask_reg != '0))
        else $error("event without last flag but nothing pending");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (rest_mask == '0) && !load) |=> (pend_mask_reg == '0))
        else $error("pending mask not empty after last event");

endmodule
